/* hdl/sliding_window_max_macros.svh */
// Assertion macros shared by the sliding-window maximum RTL.
`ifndef SLIDING_WINDOW_MAX_MACROS_SVH
`define SLIDING_WINDOW_MAX_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SWM_ASSERT_IMP(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWM_ASSERT_NXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

/* hdl/swm_pkg.sv */
// Types and constants for the sliding-window maximum block.
package swm_pkg;

  localparam int POS_BITS  = 16;
  localparam int FILL_BITS = 8;
  localparam int CFG_BITS  = 8;

  localparam logic [FILL_BITS-1:0] FILL_SAT     = 8'hFF;
  localparam logic [CFG_BITS-1:0]  WINDOW_RESET = 8'd100;

  // Control broadcast to every cell of the deque row
  typedef struct packed {
    logic                load;   // a sample is taken this cycle
    logic                clear;  // start marker: empty the deque first
    logic                shift;  // front entry aged out: move row one place
    logic [POS_BITS-1:0] pos;    // position stamp of the incoming sample
  } cell_ctrl_t;

endpackage

/* hdl/sliding_window_max.sv */
// Sliding-window maximum: top level with the deque cell row and output skid.
// Each result is registered into window_max, via the skid stage on a stall.
// Throughput: one sample per cycle while the output drains and no purge runs.
// A window_size write starts a purge, one aged-out front entry dropped per cycle
// through the cell row, with in_stall held high.
// Reset (rst, synchronous): deque emptied, counters zero, window_size = 100.
`include "sliding_window_max_macros.svh"

module sliding_window_max #(
  parameter int WINDOW_MAX  = 128,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  logic                         start_of_stream,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [SAMPLE_BITS-1:0]       window_max,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [swm_pkg::CFG_BITS-1:0] window_size
);

  localparam int WCAP = (WINDOW_MAX < 255) ? WINDOW_MAX : 255;

  logic [swm_pkg::CFG_BITS-1:0]  win_size;
  logic [swm_pkg::CFG_BITS-1:0]  weff;
  logic [swm_pkg::POS_BITS-1:0]  position_counter;
  logic [swm_pkg::POS_BITS-1:0]  position_counter_next;
  logic [swm_pkg::FILL_BITS-1:0] fill_count;
  logic [swm_pkg::FILL_BITS-1:0] fill_count_next;
  logic                          purge;
  logic                          skid_valid;
  logic [SAMPLE_BITS-1:0]        skid_max;
  logic                          in_accept;
  logic                          out_take;
  logic                          expired;
  logic                          emit;
  logic [SAMPLE_BITS-1:0]        result;
  swm_pkg::cell_ctrl_t           ctrl;

  logic                          cell_keep  [WINDOW_MAX];
  logic [WINDOW_MAX-1:0]         cell_valid;
  logic [SAMPLE_BITS-1:0]        cell_value [WINDOW_MAX];
  logic [swm_pkg::POS_BITS-1:0]  cell_pos   [WINDOW_MAX];
  logic [SAMPLE_BITS-1:0]        cell_next  [WINDOW_MAX];

  // Window size clamped to 1..min(WINDOW_MAX, 255)
  always_comb begin
    if (win_size == '0) begin
      weff = swm_pkg::CFG_BITS'(1);
    end else if (win_size > swm_pkg::CFG_BITS'(WCAP)) begin
      weff = swm_pkg::CFG_BITS'(WCAP);
    end else begin
      weff = win_size;
    end
  end

  // Front entry has aged out relative to the next position
  assign expired = cell_valid[0] &&
                   ((position_counter - cell_pos[0]) >= swm_pkg::POS_BITS'(weff));

  // Handshakes
  assign in_stall  = purge | skid_valid;
  assign in_accept = in_valid & ~in_stall;
  assign out_take  = out_valid & ~out_stall;
  assign cfg_ready = ~purge;

  // Row control
  always_comb begin
    ctrl.load  = in_accept;
    ctrl.clear = in_accept & start_of_stream;
    ctrl.shift = ((in_accept & ~start_of_stream) | purge) & expired;
    ctrl.pos   = start_of_stream ? '0 : position_counter;
  end

  // Counters and result gate
  always_comb begin
    position_counter_next = ctrl.pos + swm_pkg::POS_BITS'(1);
    if (start_of_stream) begin
      fill_count_next = swm_pkg::FILL_BITS'(1);
    end else if (fill_count == swm_pkg::FILL_SAT) begin
      fill_count_next = fill_count;
    end else begin
      fill_count_next = fill_count + swm_pkg::FILL_BITS'(1);
    end
    emit   = in_accept && (fill_count_next >= weff);
    result = cell_next[0];
  end

  // Deque cell row, cell 0 is the front
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic                         prev_keep;
    logic                         nb_valid;
    logic [SAMPLE_BITS-1:0]       nb_value;
    logic [swm_pkg::POS_BITS-1:0] nb_pos;

    if (i == 0) begin : g_first
      assign prev_keep = 1'b1;
    end else begin : g_inner
      assign prev_keep = cell_keep[i-1];
    end

    if (i == WINDOW_MAX - 1) begin : g_last
      assign nb_valid = 1'b0;
      assign nb_value = '0;
      assign nb_pos   = '0;
    end else begin : g_mid
      assign nb_valid = cell_valid[i+1];
      assign nb_value = cell_value[i+1];
      assign nb_pos   = cell_pos[i+1];
    end

    swm_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .sample    (sample),
      .prev_keep (prev_keep),
      .nb_valid  (nb_valid),
      .nb_value  (nb_value),
      .nb_pos    (nb_pos),
      .keep      (cell_keep[i]),
      .valid     (cell_valid[i]),
      .value     (cell_value[i]),
      .pos       (cell_pos[i]),
      .value_next(cell_next[i])
    );
  end

  // Control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      win_size         <= swm_pkg::WINDOW_RESET;
      position_counter <= '0;
      fill_count       <= '0;
      purge            <= 1'b0;
    end else begin
      if (in_accept) begin
        position_counter <= position_counter_next;
        fill_count       <= fill_count_next;
      end
      if (cfg_valid && cfg_ready) begin
        win_size <= window_size;
        purge    <= 1'b1;
      end else if (purge && !expired) begin
        purge <= 1'b0;
      end
    end
  end

  // Output register with a skid stage behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        window_max <= skid_max;
        skid_valid <= 1'b0;
      end
    end else if (emit) begin
      if (!out_valid || out_take) begin
        window_max <= result;
        out_valid  <= 1'b1;
      end else begin
        skid_max   <= result;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // Checks
  `SWM_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid, "skid full with output empty")
  `SWM_ASSERT_IMP(a_row_compact, !cell_valid[0], cell_valid == '0, "deque row has a gap")
  `SWM_ASSERT_NXT(a_sample_lands, in_accept, cell_valid[0], "accepted sample not held")
  `SWM_ASSERT_NXT(a_result_shown, emit, out_valid, "result not presented")
  `SWM_ASSERT_NXT(a_purge_ends, purge && !expired && !cfg_valid, !purge, "purge did not end")

endmodule

/* hdl/swm_cell.sv */
// One deque cell: holds a (position, value) entry and hands it to its neighbour.
module swm_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  swm_pkg::cell_ctrl_t          ctrl,
  input  logic [SAMPLE_BITS-1:0]       sample,
  input  logic                         prev_keep,
  input  logic                         nb_valid,
  input  logic [SAMPLE_BITS-1:0]       nb_value,
  input  logic [swm_pkg::POS_BITS-1:0] nb_pos,
  output logic                         keep,
  output logic                         valid,
  output logic [SAMPLE_BITS-1:0]       value,
  output logic [swm_pkg::POS_BITS-1:0] pos,
  output logic [SAMPLE_BITS-1:0]       value_next
);

  logic                         sh_valid;
  logic [SAMPLE_BITS-1:0]       sh_value;
  logic [swm_pkg::POS_BITS-1:0] sh_pos;
  logic                         append;
  logic                         valid_next;
  logic [swm_pkg::POS_BITS-1:0] pos_next;

  // Take the neighbour's entry when the front ages out; a clear empties the cell
  always_comb begin
    sh_valid = ctrl.clear ? 1'b0 : (ctrl.shift ? nb_valid : valid);
    sh_value = ctrl.shift ? nb_value : value;
    sh_pos   = ctrl.shift ? nb_pos : pos;
  end

  // Entries at most the new sample drop; the first free cell takes the sample
  always_comb begin
    keep       = sh_valid && (!ctrl.load || (sh_value > sample));
    append     = ctrl.load && !keep && prev_keep;
    valid_next = keep || append;
    value_next = append ? sample : sh_value;
    pos_next   = append ? ctrl.pos : sh_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    value <= value_next;
    pos   <= pos_next;
  end

endmodule
